>>> hdl/assert_macros.svh
// Assertion helpers for the polyphase interpolator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define PFI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PFI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared constants, input kind codes and controller/datapath interface types
// of the polyphase interpolator.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int TAP_COUNT_DEF   = 1024;
  localparam int PHASE_COUNT_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;

  localparam int KIND_W        = 2;
  localparam int CIDX_W        = 10;
  localparam int PHASE_FIELD_W = 4;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic take;      // input beat accepted
    logic clr_step;  // zero one history entry
    logic issue;     // read one tap/sample pair into the MAC
    logic load;      // move the finished sum to the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic tap_ok;
    logic pipe_busy;
    logic out_free;
    logic phase_last;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/polyphase_fir_interpolator_x16_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator_x16_unit
// Interpolate-by-PHASE_COUNT polyphase FIR with a single shared MAC.
// ----------------------------------------------------------------------------
// One item at a time. An audio sample beat yields PHASE_COUNT output beats;
// for each phase the one MAC does one tap per cycle, then the MAC pipeline
// drains and the sum is handed off to the output register, which waits while
// the output is stalled. A tap write or an unused kind is taken without leaving
// idle. A clear beat, and reset, start a history zeroing sweep over all
// ceil(TAP_COUNT/PHASE_COUNT) entries (64 at defaults) during which no input
// is taken. Taps must be written before the first sample uses them.
module polyphase_fir_interpolator_x16_unit #(
  parameter int TAP_COUNT   = pfi_pkg::TAP_COUNT_DEF,
  parameter int PHASE_COUNT = pfi_pkg::PHASE_COUNT_DEF,
  parameter int SAMPLE_BITS = pfi_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = pfi_pkg::COEF_BITS_DEF,
  localparam int IN_RAW_W    = SAMPLE_BITS + pfi_pkg::CIDX_W + COEF_BITS,
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]              s_axis_tdata,  // sample_in, coef_index, coef_value
  input  wire  [pfi_pkg::KIND_W-1:0]         s_axis_tuser,  // kind
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [OUT_TDATA_W-1:0]             m_axis_tdata,  // sample_out
  output logic [pfi_pkg::PHASE_FIELD_W:0]    m_axis_tuser,  // phase, block_last
  output logic                               m_axis_tlast
);

  localparam int CI_LO = SAMPLE_BITS;
  localparam int CV_LO = SAMPLE_BITS + pfi_pkg::CIDX_W;

  pfi_pkg::cmd_t    cmd;
  pfi_pkg::status_t status;

  logic signed [SAMPLE_BITS-1:0]    sample_in;
  logic [pfi_pkg::CIDX_W-1:0]       coef_index;
  logic signed [COEF_BITS-1:0]      coef_value;

  assign sample_in  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign coef_index = s_axis_tdata[CV_LO-1:CI_LO];
  assign coef_value = s_axis_tdata[IN_RAW_W-1:CV_LO];

  pfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .kind     (s_axis_tuser),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_axis_tready)
  );

  pfi_datapath #(
    .TAP_COUNT   (TAP_COUNT),
    .PHASE_COUNT (PHASE_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (s_axis_tuser),
    .sample_in  (sample_in),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .frame_last (s_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> hdl/pfi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfi_ctrl
// Sequencer: history clearing sweep, input acceptance, per-phase MAC run,
// pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module pfi_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire [pfi_pkg::KIND_W-1:0]     kind,
  input  pfi_pkg::status_t              status,
  output pfi_pkg::cmd_t                 cmd,
  output logic                          in_ready
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (kind == pfi_pkg::KIND_SAMPLE) begin
            state_next = ST_RUN;
          end else if (kind == pfi_pkg::KIND_CLEAR) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_RUN: begin
        if (status.tap_ok) begin
          cmd.issue = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.load   = 1'b1;
          state_next = status.phase_last ? ST_IDLE : ST_RUN;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/pfi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfi_datapath
// Tap memory, history ring, address counters, MAC pipeline, round/saturate
// and the output register.
// ----------------------------------------------------------------------------
module pfi_datapath #(
  parameter int TAP_COUNT    = pfi_pkg::TAP_COUNT_DEF,
  parameter int PHASE_COUNT  = pfi_pkg::PHASE_COUNT_DEF,
  parameter int SAMPLE_BITS  = pfi_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = pfi_pkg::COEF_BITS_DEF,
  parameter int OUT_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  pfi_pkg::cmd_t                       cmd,
  output pfi_pkg::status_t                    status,
  input  wire  [pfi_pkg::KIND_W-1:0]          kind,
  input  wire  signed [SAMPLE_BITS-1:0]       sample_in,
  input  wire  [pfi_pkg::CIDX_W-1:0]          coef_index,
  input  wire  signed [COEF_BITS-1:0]         coef_value,
  input  wire                                 frame_last,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [OUT_TDATA_W-1:0]              out_data,
  output logic [pfi_pkg::PHASE_FIELD_W:0]     out_user,
  output logic                                out_last
);

  localparam int HIST_DEPTH = (TAP_COUNT + PHASE_COUNT - 1) / PHASE_COUNT;
  localparam int HIST_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int ADDR_W     = $clog2(TAP_COUNT);
  localparam int TAP_CW     = $clog2(TAP_COUNT + PHASE_COUNT + 1);
  localparam int PHASE_W    = $clog2(PHASE_COUNT);
  localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W      = PROD_W + HIST_W + 1;
  localparam int PF_W       = pfi_pkg::PHASE_FIELD_W;

  localparam longint HALF_L = longint'(1) << (COEF_BITS - 2);
  localparam longint SMAX_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN_L = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(HALF_L);
  localparam logic signed [ACC_W:0] SMAX = (ACC_W + 1)'(SMAX_L);
  localparam logic signed [ACC_W:0] SMIN = (ACC_W + 1)'(SMIN_L);

  logic signed [COEF_BITS-1:0]   coef_mem [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];

  logic [HIST_W-1:0]  wp;
  logic [HIST_W-1:0]  newest;
  logic [HIST_W-1:0]  rd;
  logic [HIST_W-1:0]  clr_addr;
  logic [TAP_CW-1:0]  tap;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W:0]   phase_inc;
  logic               blk_last;

  logic                          coef_we;
  logic                          hist_we;
  logic [HIST_W-1:0]             hist_wa;
  logic signed [SAMPLE_BITS-1:0] hist_wd;
  logic                          is_sample;

  logic signed [COEF_BITS-1:0]   coef_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic                          v1;
  logic                          v2;

  logic signed [ACC_W:0]         rsum;
  logic signed [ACC_W:0]         rq;
  logic [SAMPLE_BITS-1:0]        sat;

  assign is_sample = cmd.take && (kind == pfi_pkg::KIND_SAMPLE);
  assign coef_we   = cmd.take && (kind == pfi_pkg::KIND_COEF) &&
                     (32'(coef_index) < 32'(TAP_COUNT));
  assign hist_we   = cmd.clr_step || is_sample;
  assign hist_wa   = cmd.clr_step ? clr_addr : wp;
  assign hist_wd   = cmd.clr_step ? '0 : sample_in;
  assign phase_inc = {1'b0, phase} + 1'b1;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[ADDR_W'(coef_index)] <= coef_value;
    end
    coef_q <= coef_mem[ADDR_W'(tap)];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q <= hist_mem[rd];
  end

  // ring pointer and clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.take && (kind == pfi_pkg::KIND_CLEAR)) begin
        wp <= '0;
      end else if (is_sample) begin
        wp <= (wp == HIST_W'(HIST_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (cmd.clr_step) begin
        clr_addr <= (clr_addr == HIST_W'(HIST_DEPTH - 1)) ? '0 : clr_addr + 1'b1;
      end
    end
  end

  // per-phase walk: tap = P*k + p, history index = newest - k
  always_ff @(posedge clk) begin
    if (is_sample) begin
      newest   <= wp;
      rd       <= wp;
      tap      <= '0;
      phase    <= '0;
      blk_last <= frame_last;
    end else if (cmd.issue) begin
      rd  <= (rd == '0) ? HIST_W'(HIST_DEPTH - 1) : rd - 1'b1;
      tap <= tap + TAP_CW'(PHASE_COUNT);
    end else if (cmd.load) begin
      rd    <= newest;
      tap   <= TAP_CW'(phase_inc);
      phase <= PHASE_W'(phase_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= hist_q * coef_q;
    if (is_sample || cmd.load) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_comb begin
    rsum = {acc[ACC_W-1], acc} + HALF;
    rq   = rsum >>> (COEF_BITS - 1);
    if (rq > SMAX) begin
      sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else if (rq < SMIN) begin
      sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      sat = rq[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= OUT_TDATA_W'(sat);
      out_last <= (phase == PHASE_W'(PHASE_COUNT - 1));
      out_user <= {(phase == PHASE_W'(PHASE_COUNT - 1)) && blk_last, PF_W'(phase)};
    end
  end

  always_comb begin
    status            = '0;
    status.clr_last   = (clr_addr == HIST_W'(HIST_DEPTH - 1));
    status.tap_ok     = (tap < TAP_CW'(TAP_COUNT));
    status.pipe_busy  = v1 || v2;
    status.out_free   = !out_valid || out_ready;
    status.phase_last = (phase == PHASE_W'(PHASE_COUNT - 1));
  end

endmodule
`default_nettype wire

>>> hdl/pfi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfi_checker
// Port-level checks of the polyphase interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfi_checker #(
  parameter int PHASE_COUNT = pfi_pkg::PHASE_COUNT_DEF,
  parameter int OUT_TDATA_W = 16
) (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire [pfi_pkg::KIND_W-1:0]        s_axis_tuser,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [OUT_TDATA_W-1:0]            m_axis_tdata,
  input wire [pfi_pkg::PHASE_FIELD_W:0]   m_axis_tuser,
  input wire                              m_axis_tlast
);

  localparam int PF_W = pfi_pkg::PHASE_FIELD_W;
  localparam logic [PF_W-1:0] LAST_PHASE = PF_W'(PHASE_COUNT - 1);

  `PFI_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !s_axis_tready && !m_axis_tvalid, "reset did not quiet both channels")

  `PFI_ASSERT(a_last_on_final_phase, clk, rst, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[PF_W-1:0] == LAST_PHASE)), "tlast not on final phase")

  `PFI_ASSERT(a_block_implies_last, clk, rst, m_axis_tvalid && m_axis_tuser[PF_W] |-> m_axis_tlast, "block_last without run end")

  `PFI_ASSERT(a_busy_after_sample, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == pfi_pkg::KIND_SAMPLE) |=> !s_axis_tready, "input taken while a sample is in progress")

  `PFI_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output beat changed")

endmodule

bind polyphase_fir_interpolator_x16_unit pfi_checker #(
  .PHASE_COUNT (PHASE_COUNT),
  .OUT_TDATA_W (OUT_TDATA_W)
) u_pfi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> tb/sv/interp_x16_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interp_x16_checker
// Watches both streams of the x16 polyphase interpolator. It keeps its own
// copy of the tap store, the sample history and the write pointer. For every
// accepted sample it computes the sixteen phase outputs and queues them. Each
// output beat is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module interp_x16_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // sample_in, coef_index, coef_value
  input  wire  [1:0]  s_axis_tuser,   // kind
  input  wire         s_axis_tlast,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [15:0] m_axis_tdata,   // sample_out
  input  wire  [4:0]  m_axis_tuser,   // phase, block_last
  input  wire         m_axis_tlast,
  output int          fail_count,
  output int          pending
);

  localparam int TAPS   = pfi_pkg::TAP_COUNT_DEF;
  localparam int PHASES = pfi_pkg::PHASE_COUNT_DEF;
  localparam int HIST   = (TAPS + PHASES - 1) / PHASES;
  localparam int SBITS  = pfi_pkg::SAMPLE_BITS_DEF;
  localparam int CBITS  = pfi_pkg::COEF_BITS_DEF;
  localparam int PF_W   = pfi_pkg::PHASE_FIELD_W;
  localparam longint OUT_MAX = (64'sd1 <<< (SBITS - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct packed {
    logic [SBITS-1:0] value;
    logic [PF_W-1:0]  phase;
    logic             run_last;
    logic             block_last;
  } interp_beat_t;

  logic signed [CBITS-1:0] tap_store [TAPS];
  logic signed [SBITS-1:0] history [HIST];
  int                      wr_ptr;
  interp_beat_t            phase_outputs_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    wr_ptr     = 0;
    for (int i = 0; i < TAPS; i++) tap_store[i] = '0;
    for (int i = 0; i < HIST; i++) history[i] = '0;
  end

  task automatic clear_history();
    for (int i = 0; i < HIST; i++) history[i] = '0;
    wr_ptr = 0;
  endtask

  task automatic compute_phase_outputs(input logic signed [SBITS-1:0] smp,
                                       input logic frame_end);
    int           newest;
    longint       acc;
    longint       r;
    interp_beat_t b;
    history[wr_ptr] = smp;
    newest = wr_ptr;
    wr_ptr = (wr_ptr + 1) % HIST;
    for (int p = 0; p < PHASES; p++) begin
      acc = 0;
      for (int k = 0; k < HIST && k * PHASES + p < TAPS; k++) begin
        acc += longint'(history[(newest + HIST - k) % HIST]) *
               longint'(tap_store[k * PHASES + p]);
      end
      r = (acc + (64'sd1 <<< (CBITS - 2))) >>> (CBITS - 1);
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      b.value      = r[SBITS-1:0];
      b.phase      = p[PF_W-1:0];
      b.run_last   = (p == PHASES - 1);
      b.block_last = (p == PHASES - 1) && frame_end;
      phase_outputs_q.push_back(b);
    end
  endtask

  function automatic int check_field(input string name, input int expd, input int got);
    if (expd == got) return 0;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expd, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    int           errs;
    interp_beat_t want;
    errs = 0;
    if (rst) begin
      clear_history();
      phase_outputs_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (phase_outputs_q.size() == 0) begin
          $display("%0t ns: output beat with nothing expected, actual sample_out %0d phase %0d",
                   $time, $signed(m_axis_tdata), m_axis_tuser[3:0]);
          errs++;
        end else begin
          want = phase_outputs_q.pop_front();
          errs += check_field("sample_out", $signed(want.value), $signed(m_axis_tdata));
          errs += check_field("phase", want.phase, m_axis_tuser[3:0]);
          errs += check_field("run_last", want.run_last, m_axis_tlast);
          errs += check_field("block_last", want.block_last, m_axis_tuser[4]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          pfi_pkg::KIND_COEF:   tap_store[s_axis_tdata[25:16]] = s_axis_tdata[43:26];
          pfi_pkg::KIND_CLEAR:  clear_history();
          pfi_pkg::KIND_SAMPLE: compute_phase_outputs(s_axis_tdata[15:0], s_axis_tlast);
          default: ;
        endcase
      end
      fail_count <= fail_count + errs;
      pending    <= phase_outputs_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the x16 polyphase interpolator. Taps are loaded in
// full before any sample. A short directed run covers sample and tap extremes,
// rounding ties, frame marks, clears and the unused kind. Random traffic then
// runs under small, full-range and maximum tap sets, the later sets written as
// partial reloads. Both sides idle at random, with burst stretches, one long
// output hold-off and one drain-to-empty pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [pfi_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int TAPS        = pfi_pkg::TAP_COUNT_DEF;
  localparam int PHASES      = pfi_pkg::PHASE_COUNT_DEF;
  localparam int PART_LOAD   = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN       = 1200;
  localparam int LONG_HOLD   = 3000;
  localparam int HOLD_AT     = 160;

  typedef enum int {TAPS_SMALL, TAPS_FULL, TAPS_MAX} tap_set_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // sample_in, coef_index, coef_value
  logic [1:0]  s_axis_tuser;   // kind
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // sample_out
  logic [4:0]  m_axis_tuser;   // phase, block_last
  logic        m_axis_tlast;

  int       fail_count;
  int       pending;
  logic     burst;
  tap_set_t tap_set;
  int       quiet_cycles;
  int       rx_beats;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  polyphase_fir_interpolator_x16_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  interp_x16_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic logic [17:0] tap_value(input tap_set_t set);
    case (set)
      TAPS_SMALL: return 18'($signed($urandom_range(0, 8191)) - 4096);
      TAPS_MAX:   return 18'h1FFFF;
      default:    return 18'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high across back-to-back beats; it drops only when a gap is drawn
  task automatic send_beat(input logic [1:0] kind, input logic [15:0] smp,
                           input logic [9:0] idx, input logic [17:0] coef,
                           input logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, coef, idx, smp};
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic last);
    send_beat(pfi_pkg::KIND_SAMPLE, smp, 10'($urandom), 18'($urandom), last);
  endtask

  task automatic send_tap(input logic [9:0] idx, input logic [17:0] coef);
    send_beat(pfi_pkg::KIND_COEF, 16'($urandom), idx, coef, 1'($urandom));
  endtask

  task automatic send_clear(input logic last);
    send_beat(pfi_pkg::KIND_CLEAR, 16'($urandom), 10'($urandom), 18'($urandom), last);
  endtask

  // n >= TAPS writes every tap in order; smaller n rewrites random taps
  task automatic load_taps(input tap_set_t set, input int n);
    tap_set = set;
    if (n >= TAPS) begin
      for (int i = 0; i < TAPS; i++) send_tap(10'(i), tap_value(set));
    end else begin
      repeat (n) send_tap(10'($urandom_range(0, TAPS - 1)), tap_value(set));
    end
  endtask

  task automatic random_items(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 80)
        send_sample(rand_sample(), $urandom_range(0, 3) == 0);
      else if (sel < 90)
        send_tap(10'($urandom_range(0, TAPS - 1)), tap_value(tap_set));
      else if (sel < 95)
        send_clear(1'($urandom));
      else
        send_beat(KIND_UNUSED, 16'($urandom), 10'($urandom), 18'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // output side
  initial begin : receiver
    int gap;
    m_axis_tready <= 1'b0;
    rx_beats = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_beats == HOLD_AT) gap = LONG_HOLD;
      else gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      rx_beats++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** polyphase_fir_interpolator_x16_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= pfi_pkg::KIND_SAMPLE;
    s_axis_tlast  <= 1'b0;
    burst         <= 1'b1;
    quiet_cycles  <= 0;
    tap_set        = TAPS_SMALL;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    load_taps(TAPS_SMALL, TAPS);
    burst <= 1'b0;

    // directed: unused kind, tap extremes, rounding ties, sample extremes, marks
    send_beat(KIND_UNUSED, 16'h7FFF, 10'h3FF, 18'h3FFFF, 1'b1);
    send_tap(10'd0, 18'd65536);
    send_tap(10'd1, 18'h20000);
    send_tap(10'd15, 18'h1FFFF);
    send_clear(1'b0);
    send_sample(16'd1, 1'b1);
    send_clear(1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_clear(1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_tap(10'd1023, 18'h1FFFF);
    send_tap(10'd1008, 18'h20000);
    send_sample(16'h7FFF, 1'b1);
    send_beat(KIND_UNUSED, 16'h0000, 10'h000, 18'h00000, 1'b0);
    send_beat(pfi_pkg::KIND_COEF, 16'h8000, 10'd512, 18'h00001, 1'b1);
    send_sample(16'h8000, 1'b0);

    random_items(70);
    drain_outputs();

    burst <= 1'b1;
    random_items(40);
    burst <= 1'b0;

    load_taps(TAPS_FULL, PART_LOAD);
    random_items(50);

    // full-scale phase 0 taps over a cleared history: sums saturate both ways
    load_taps(TAPS_MAX, PART_LOAD);
    send_clear(1'b0);
    for (int k = 0; k < 4; k++) send_tap(10'(k * PHASES), 18'h1FFFF);
    repeat (2) send_sample(16'h7FFF, 1'b0);
    repeat (3) send_sample(16'h8000, 1'b1);
    random_items(30);

    load_taps(TAPS_SMALL, PART_LOAD);
    random_items(30);

    drain_outputs();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("** polyphase_fir_interpolator_x16_unit: PASSED **");
    end else begin
      $display("** polyphase_fir_interpolator_x16_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> polyphase_fir_interpolator_x16_unit.f
+incdir+hdl
hdl/pfi_pkg.sv
hdl/pfi_ctrl.sv
hdl/pfi_datapath.sv
hdl/polyphase_fir_interpolator_x16_unit.sv
hdl/pfi_checker.sv
tb/sv/interp_x16_checker.sv
tb/sv/tb_top.sv
